@@ rtl/stc_pkg.sv @@
// Shared types, register indexes and sign-extension helpers for the sensor compensation block.
`default_nettype none
package stc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_MIXED   = 3'd3;
  localparam logic [2:0] REG_HUM     = 3'd4;

  // Humidity clamp ceiling (Q10.22, which is Q22.10 after the 12-bit shift)
  localparam logic [31:0] HUM_CLAMP = 32'd419430400;

  // Decoded calibration words
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [7:0]  h6;
  } stc_coef_t;

  // Raw readings still waiting for their path
  typedef struct packed {
    logic [19:0] adc_press;
    logic [15:0] adc_hum;
  } stc_raw_t;

  // Temperature stage to humidity stage
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    stc_raw_t    raw;
  } stc_th_t;

  // Finished temperature and humidity values
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic [16:0] hum;
  } stc_side_t;

  // Humidity stage to pressure stage
  typedef struct packed {
    stc_side_t   side;
    logic [19:0] adc_press;
  } stc_hp_t;

  // Complete result
  typedef struct packed {
    stc_side_t   side;
    logic [31:0] press;
  } stc_res_t;

  function automatic logic [31:0] sx8_32(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] sx16_32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx16_64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx32_64(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage
`default_nettype wire

@@ rtl/stc_mul64.sv @@
// Two-stage 64x64 multiplier keeping the low 64 product bits (wrapping).
`default_nettype none
module stc_mul64 (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic      [63:0] p
);

  logic [63:0] ll_r;
  logic [31:0] cr_r;
  logic [63:0] p_r;

  // Stage 1: low x low full product, cross products mod 2^32
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[31:0] * b[31:0];
      cr_r <= a[63:32] * b[31:0] + a[31:0] * b[63:32];
    end
  end

  // Stage 2: fold cross terms into the upper word
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= ll_r + {cr_r, 32'd0};
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

@@ rtl/stc_temp.sv @@
// Temperature pipeline: five stages producing fine temperature and centi-degrees.
`default_nettype none
module stc_temp import stc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [19:0] adc_temp,
  input  wire stc_raw_t    raw,
  input  wire stc_coef_t   coef,
  output logic             out_valid,
  output stc_th_t          out_data
);

  localparam int NS = 5;

  logic [NS:1] vld_r;
  stc_raw_t    raw_r [1:NS];
  logic [31:0] ta_r, dt_r, ma_r, mdd_r, a_r, mb_r, fine4_r, fine5_r, temp_r;
  logic [31:0] t1z, t2s, t3s, mdd_sh, fine_x5;

  assign t1z     = {16'd0, coef.t1};
  assign t2s     = sx16_32(coef.t2);
  assign t3s     = sx16_32(coef.t3);
  assign mdd_sh  = 32'($signed(mdd_r) >>> 12);
  assign fine_x5 = {fine4_r[29:0], 2'b00} + fine4_r;

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-1:1], in_valid};
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (en) begin
      raw_r[1] <= raw;
      for (int k = 2; k <= NS; k++) raw_r[k] <= raw_r[k-1];
      // stage 1: offsets
      ta_r    <= {15'd0, adc_temp[19:3]} - {15'd0, coef.t1, 1'b0};
      dt_r    <= {16'd0, adc_temp[19:4]} - t1z;
      // stage 2: products
      ma_r    <= ta_r * t2s;
      mdd_r   <= dt_r * dt_r;
      // stage 3
      a_r     <= 32'($signed(ma_r) >>> 11);
      mb_r    <= mdd_sh * t3s;
      // stage 4: fine temperature
      fine4_r <= a_r + 32'($signed(mb_r) >>> 14);
      // stage 5: scaled temperature
      fine5_r <= fine4_r;
      temp_r  <= 32'($signed(fine_x5 + 32'd128) >>> 8);
    end
  end

  assign out_valid     = vld_r[NS];
  assign out_data.temp = temp_r;
  assign out_data.fine = fine5_r;
  assign out_data.raw  = raw_r[NS];

endmodule
`default_nettype wire

@@ rtl/stc_hum.sv @@
// Humidity pipeline: ten stages of 32-bit wrapping arithmetic with final clamp.
`default_nettype none
module stc_hum import stc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire stc_th_t   in_data,
  input  wire stc_coef_t coef,
  output logic           out_valid,
  output stc_hp_t        out_data
);

  localparam int NS = 10;

  logic [NS:1] vld_r;
  stc_th_t     sd_r [1:NS];
  logic [31:0] v_r, mh5_r, my1_r, my2_r, x3_r, y1_r, y2_r, my3_r, x4_r;
  logic [31:0] my_r, x5_r, y_r, x6_r, w7_r, msq_r, w8_r, t_r, w9_r;
  logic [16:0] hum_r;
  logic [31:0] h1z, h2s, h3z, h4s, h5s, h6s, x_sum, sq, w2, w2c;

  assign h1z = {24'd0, coef.h1};
  assign h2s = sx16_32(coef.h2);
  assign h3z = {24'd0, coef.h3};
  assign h4s = sx16_32(coef.h4);
  assign h5s = sx16_32(coef.h5);
  assign h6s = sx8_32(coef.h6);

  assign x_sum = {2'b00, sd_r[2].raw.adc_hum, 14'd0} - {h4s[11:0], 20'd0} - mh5_r
                 + 32'd16384;
  assign sq    = 32'($signed(w7_r) >>> 15);

  // Clamp to 0..HUM_CLAMP
  always_comb begin
    w2 = w9_r - 32'($signed(t_r) >>> 4);
    priority if (w2[31]) begin
      w2c = '0;
    end else if (w2 > HUM_CLAMP) begin
      w2c = HUM_CLAMP;
    end else begin
      w2c = w2;
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-1:1], in_valid};
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[1] <= in_data;
      for (int k = 2; k <= NS; k++) sd_r[k] <= sd_r[k-1];
      v_r   <= in_data.fine - 32'd76800;
      mh5_r <= h5s * v_r;
      my1_r <= v_r * h6s;
      my2_r <= v_r * h3z;
      x3_r  <= 32'($signed(x_sum) >>> 15);
      y1_r  <= 32'($signed(my1_r) >>> 10);
      y2_r  <= 32'($signed(my2_r) >>> 11) + 32'd32768;
      my3_r <= y1_r * y2_r;
      x4_r  <= x3_r;
      my_r  <= (32'($signed(my3_r) >>> 10) + 32'd2097152) * h2s;
      x5_r  <= x4_r;
      y_r   <= 32'($signed(my_r + 32'd8192) >>> 14);
      x6_r  <= x5_r;
      w7_r  <= x6_r * y_r;
      msq_r <= sq * sq;
      w8_r  <= w7_r;
      t_r   <= 32'($signed(msq_r) >>> 7) * h1z;
      w9_r  <= w8_r;
      hum_r <= w2c[28:12];
    end
  end

  assign out_valid           = vld_r[NS];
  assign out_data.side.temp  = sd_r[NS].temp;
  assign out_data.side.fine  = sd_r[NS].fine;
  assign out_data.side.hum   = hum_r;
  assign out_data.adc_press  = sd_r[NS].raw.adc_press;

endmodule
`default_nettype wire

@@ rtl/stc_press.sv @@
// Pressure pipeline: 64-bit wrapping products, 64-step restoring divider, correction terms.
`default_nettype none
module stc_press import stc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire stc_hp_t   in_data,
  input  wire stc_coef_t coef,
  output logic           out_valid,
  output stc_res_t       out_data
);

  localparam int NS    = 81;   // total stages
  localparam int DIV0  = 10;   // divider entry stage
  localparam int DIV_N = 64;   // quotient bits, one per stage

  logic [NS:1]   vld_r;
  stc_side_t     sd_r [1:NS];
  logic          dz_r [DIV0:NS-1];
  logic [95:0]   dv_r [0:DIV_N];
  logic [31:0]   dd_r [0:DIV_N-1];
  logic          ng_r [0:DIV_N];

  logic [63:0] v1_r, pp1_r, pp2_r, pp3_r, pp4_r, pp5_r, pp6_r;
  logic [63:0] m2_4_r, m2_5_r, m4_4_r, m4_5_r, v2_r, wv6_r, wv7_r, nn_r;
  logic [63:0] q_r, q76_r, q77_r, q78_r, q79_r, m9_78_r, m9_79_r, s_r;
  logic [31:0] press_r;
  logic [63:0] m1, m2, m4, v2a, m3, m5, m6, m7, m8, m9;
  logic [63:0] p1z, p2s, p3s, p4s, p5s, p6s, p8s, p9s, mn, qs77, qu;
  logic [31:0] md, p7s;
  logic [30:0] dsg;

  assign p1z  = {48'd0, coef.p1};
  assign p2s  = sx16_64(coef.p2);
  assign p3s  = sx16_64(coef.p3);
  assign p4s  = sx16_64(coef.p4);
  assign p5s  = sx16_64(coef.p5);
  assign p6s  = sx16_64(coef.p6);
  assign p7s  = sx16_32(coef.p7);
  assign p8s  = sx16_64(coef.p8);
  assign p9s  = sx16_64(coef.p9);

  // Divider operand magnitudes
  assign dsg  = m5[63:33];
  assign md   = dsg[30] ? (32'd0 - {1'b1, dsg}) : {1'b0, dsg};
  assign mn   = m6[63] ? (64'd0 - m6) : m6;
  assign qu   = dv_r[DIV_N][63:0];
  assign qs77 = 64'($signed(q77_r) >>> 13);

  // One restoring step: shift in the next numerator bit, subtract if it fits
  function automatic logic [95:0] div_step(input logic [95:0] rq, input logic [31:0] d);
    logic [96:0] sh;
    logic [32:0] tr;
    sh = {rq, 1'b0};
    tr = sh[96:64];
    if (tr >= {1'b0, d}) begin
      tr    = tr - {1'b0, d};
      sh[0] = 1'b1;
    end
    return {tr[31:0], sh[63:0]};
  endfunction

  // Products: first level (stage 1 -> 3)
  stc_mul64 u_m1 (.clk(clk), .en(en), .a(v1_r),  .b(v1_r), .p(m1));
  stc_mul64 u_m2 (.clk(clk), .en(en), .a(v1_r),  .b(p5s),  .p(m2));
  stc_mul64 u_m4 (.clk(clk), .en(en), .a(v1_r),  .b(p2s),  .p(m4));
  // second level (stage 3 -> 5)
  stc_mul64 u_v2 (.clk(clk), .en(en), .a(m1),    .b(p6s),  .p(v2a));
  stc_mul64 u_m3 (.clk(clk), .en(en), .a(m1),    .b(p3s),  .p(m3));
  // divisor and numerator (stage 7 -> 9)
  stc_mul64 u_m5 (.clk(clk), .en(en), .a(wv7_r), .b(p1z),  .p(m5));
  stc_mul64 u_m6 (.clk(clk), .en(en), .a(nn_r),  .b(64'd3125), .p(m6));
  // correction terms (stage 75 -> 77 -> 79)
  stc_mul64 u_m7 (.clk(clk), .en(en), .a(p9s),   .b(64'($signed(q_r) >>> 13)), .p(m7));
  stc_mul64 u_m9 (.clk(clk), .en(en), .a(p8s),   .b(q_r),  .p(m9));
  stc_mul64 u_m8 (.clk(clk), .en(en), .a(m7),    .b(qs77), .p(m8));

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-1:1], in_valid};
    end
  end

  // Sideband and divide-guard flags follow their sample
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[1] <= in_data.side;
      for (int k = 2; k <= NS; k++) sd_r[k] <= sd_r[k-1];
      dz_r[DIV0] <= (dsg == '0);
      for (int k = DIV0 + 1; k <= NS - 1; k++) dz_r[k] <= dz_r[k-1];
    end
  end

  // Front end: offsets, sums and numerator
  always_ff @(posedge clk) begin
    if (en) begin
      v1_r   <= sx32_64(in_data.side.fine) - 64'd128000;
      pp1_r  <= 64'd1048576 - {44'd0, in_data.adc_press};
      pp2_r  <= pp1_r;
      pp3_r  <= pp2_r;
      pp4_r  <= pp3_r;
      pp5_r  <= pp4_r;
      pp6_r  <= pp5_r;
      m2_4_r <= m2;
      m2_5_r <= m2_4_r;
      m4_4_r <= m4;
      m4_5_r <= m4_4_r;
      v2_r   <= v2a + {m2_5_r[46:0], 17'd0} + {p4s[28:0], 35'd0};
      wv6_r  <= 64'h0000_8000_0000_0000 + 64'($signed(m3) >>> 8) + {m4_5_r[51:0], 12'd0};
      wv7_r  <= wv6_r;
      nn_r   <= {pp6_r[32:0], 31'd0} - v2_r;
    end
  end

  // Divider: entry stage then one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= {32'd0, mn};
      dd_r[0] <= md;
      ng_r[0] <= m6[63] ^ m5[63];
      for (int k = 1; k <= DIV_N; k++) begin
        dv_r[k] <= div_step(dv_r[k-1], dd_r[k-1]);
        ng_r[k] <= ng_r[k-1];
      end
      for (int k = 1; k <= DIV_N - 1; k++) dd_r[k] <= dd_r[k-1];
    end
  end

  // Back end: signed quotient, correction sums, final scaling
  always_ff @(posedge clk) begin
    if (en) begin
      q_r     <= ng_r[DIV_N] ? (64'd0 - qu) : qu;
      q76_r   <= q_r;
      q77_r   <= q76_r;
      q78_r   <= q77_r;
      q79_r   <= q78_r;
      m9_78_r <= m9;
      m9_79_r <= m9_78_r;
      s_r     <= q79_r + 64'($signed(m8) >>> 25) + 64'($signed(m9_79_r) >>> 19);
      press_r <= dz_r[NS-1] ? 32'd0 : (s_r[39:8] + {p7s[27:0], 4'd0});
    end
  end

  assign out_valid      = vld_r[NS];
  assign out_data.side  = sd_r[NS];
  assign out_data.press = press_r;

endmodule
`default_nettype wire

@@ rtl/sensor_thp_compensation_top.sv @@
// Top level: calibration registers, flow control and the three compensation pipelines.
//
//  channel  | ports                                    | direction
//  ---------+------------------------------------------+----------
//  input    | in_valid/in_ready, adc_temp/press/hum    | in
//  result   | out_valid/out_ready, temp/press/hum/fine | out
//  config   | cfg_we, cfg_index, cfg_wdata             | in
//
// One sample per cycle while no result is held; latency is set mostly by the 64-stage
// divider in the pressure path (temperature 5, humidity 10, pressure 81 stages).
// rst_n clears the valid bits and the calibration registers (all zero).
// A result held at the output freezes every stage together; the input is
// ready whenever the output register is empty or being taken.
`default_nettype none
module sensor_thp_compensation_top import stc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [19:0] in_adc_temp,
  input  wire logic [19:0] in_adc_press,
  input  wire logic [15:0] in_adc_hum,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_temperature_centi,
  output logic [31:0]      out_pressure_q24_8,
  output logic [16:0]      out_humidity_q22_10,
  output logic [31:0]      out_fine_temp,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  logic [47:0] temp_coeffs_r, mixed_coeffs_r;
  logic [63:0] press_a_r, press_b_r;
  logic [39:0] hum_coeffs_r;
  stc_coef_t   coef;
  stc_raw_t    raw;
  logic        en, t_valid, h_valid;
  stc_th_t     t_data;
  stc_hp_t     h_data;
  stc_res_t    res;

  // Calibration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r  <= '0;
      press_a_r      <= '0;
      press_b_r      <= '0;
      mixed_coeffs_r <= '0;
      hum_coeffs_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP:    temp_coeffs_r  <= cfg_wdata[47:0];
        REG_PRESS_A: press_a_r      <= cfg_wdata;
        REG_PRESS_B: press_b_r      <= cfg_wdata;
        REG_MIXED:   mixed_coeffs_r <= cfg_wdata[47:0];
        REG_HUM:     hum_coeffs_r   <= cfg_wdata[39:0];
        default:     ;
      endcase
    end
  end

  // Field decode
  always_comb begin
    coef.t1 = temp_coeffs_r[15:0];
    coef.t2 = temp_coeffs_r[31:16];
    coef.t3 = temp_coeffs_r[47:32];
    coef.p1 = press_a_r[15:0];
    coef.p2 = press_a_r[31:16];
    coef.p3 = press_a_r[47:32];
    coef.p4 = press_a_r[63:48];
    coef.p5 = press_b_r[15:0];
    coef.p6 = press_b_r[31:16];
    coef.p7 = press_b_r[47:32];
    coef.p8 = press_b_r[63:48];
    coef.p9 = mixed_coeffs_r[15:0];
    coef.h1 = mixed_coeffs_r[23:16];
    coef.h2 = mixed_coeffs_r[39:24];
    coef.h3 = mixed_coeffs_r[47:40];
    coef.h4 = hum_coeffs_r[15:0];
    coef.h5 = hum_coeffs_r[31:16];
    coef.h6 = hum_coeffs_r[39:32];
  end

  // Whole pipeline advances unless a finished result is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign raw.adc_press = in_adc_press;
  assign raw.adc_hum   = in_adc_hum;

  stc_temp u_temp (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .adc_temp(in_adc_temp), .raw(raw), .coef(coef),
    .out_valid(t_valid), .out_data(t_data)
  );

  stc_hum u_hum (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t_valid),
    .in_data(t_data), .coef(coef),
    .out_valid(h_valid), .out_data(h_data)
  );

  stc_press u_press (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(h_valid),
    .in_data(h_data), .coef(coef),
    .out_valid(out_valid), .out_data(res)
  );

  assign out_temperature_centi = res.side.temp;
  assign out_fine_temp         = res.side.fine;
  assign out_humidity_q22_10   = res.side.hum;
  assign out_pressure_q24_8    = res.press;

endmodule
`default_nettype wire
